### design/sfrc_pkg.sv
// Shared types and constants for the servo frame receive checker.
package sfrc_pkg;

   // Status codes reported at the end of a frame.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_TIMEOUT  = 3'd1;
   localparam logic [2:0] ST_HEADER   = 3'd2;
   localparam logic [2:0] ST_ID       = 3'd3;
   localparam logic [2:0] ST_LENGTH   = 3'd4;
   localparam logic [2:0] ST_CHECKSUM = 3'd5;

   // Command codes of a request.
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_IDLE = 1'b1;

   // Register indexes of the configuration port.
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_EXPECTED_LENGTH = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TIMEOUT_LIMIT   = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_OWN_ID          = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BROADCAST_ID    = 4'd3;

   // Frame constants.
   localparam logic [7:0]  SYNC_BYTE    = 8'hFF;
   localparam logic [7:0]  VARIABLE_LEN = 8'hFF;
   localparam logic [15:0] CHECK_GOOD   = 16'hFFFF;

   // Register reset values.
   localparam logic [7:0]  RST_EXPECTED_LENGTH = 8'd255;
   localparam logic [15:0] RST_TIMEOUT_LIMIT   = 16'd500;
   localparam logic [7:0]  RST_OWN_ID          = 8'd0;
   localparam logic [7:0]  RST_BROADCAST_ID    = 8'd254;

   typedef struct packed {
      logic [7:0]  expected_length;
      logic [15:0] timeout_limit;
      logic [7:0]  own_id;
      logic [7:0]  broadcast_id;
   } cfg_type;

   typedef struct packed {
      logic       done;
      logic [2:0] status;
      logic [7:0] frame_bytes;
   } result_type;

endpackage

### design/sfrc_if.sv
// Handshake channel interfaces for requests, results and register writes.
interface sfrc_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_byte;

   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface sfrc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] frame_bytes;

   modport source (output valid, output status, output frame_bytes, input ready);
   modport sink (input valid, input status, input frame_bytes, output ready);
endinterface

interface sfrc_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### design/sfrc_csr.sv
// Configuration register file of the frame checker.
module sfrc_csr
   import sfrc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [CSR_INDEX_W-1:0] wr_index,
   input  logic [CSR_DATA_W-1:0]  wr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_EXPECTED_LENGTH: cfg_in.expected_length = wr_data[7:0];
            REG_TIMEOUT_LIMIT:   cfg_in.timeout_limit   = wr_data;
            REG_OWN_ID:          cfg_in.own_id          = wr_data[7:0];
            REG_BROADCAST_ID:    cfg_in.broadcast_id    = wr_data[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_length <= RST_EXPECTED_LENGTH;
         cfg_ff.timeout_limit   <= RST_TIMEOUT_LIMIT;
         cfg_ff.own_id          <= RST_OWN_ID;
         cfg_ff.broadcast_id    <= RST_BROADCAST_ID;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/sfrc_frame.sv
// Frame state tracker and end-of-frame status evaluation.
module sfrc_frame
   import sfrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       cmd,
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   output result_type result
);

   logic [7:0]  byte_count_ff, byte_count_in;
   logic [15:0] idle_count_ff, idle_count_in;
   // Sum of bytes from index 2 up to, but not including, the last two bytes.
   logic [15:0] lag_sum_ff, lag_sum_in;
   logic        header_bad_ff, header_bad_in;
   logic [7:0]  id_byte_ff, id_byte_in;
   logic [7:0]  length_byte_ff, length_byte_in;
   logic [7:0]  older_ff, older_in;
   logic [7:0]  newer_ff, newer_in;

   logic [16:0] ticks;
   logic [8:0]  count_next;
   logic        timeout_hit;
   logic        length_hit;
   logic        finish;
   logic        by_timeout;
   logic [7:0]  upd_count;
   logic [15:0] upd_lag_sum;
   logic        upd_header_bad;
   logic [7:0]  upd_id;
   logic [7:0]  upd_length;
   logic [7:0]  ev_count;
   logic [15:0] ev_lag_sum;
   logic        ev_header_bad;
   logic [7:0]  ev_id;
   logic [7:0]  ev_length;
   logic [7:0]  ev_older;
   logic [7:0]  ev_newer;
   logic [15:0] check_sum;
   logic [2:0]  status;
   logic [7:0]  frame_bytes;

   // Byte path: state after taking in this byte.
   always_comb begin
      count_next     = {1'b0, byte_count_ff} + 9'd1;
      upd_count      = count_next[7:0];
      upd_header_bad = header_bad_ff;
      upd_length     = length_byte_ff;
      upd_id         = id_byte_ff;
      upd_lag_sum    = lag_sum_ff;
      if (byte_count_ff < 8'd2) begin
         upd_header_bad = header_bad_ff | (rx_byte != SYNC_BYTE);
      end
      if (byte_count_ff == 8'd2) begin
         upd_length = rx_byte;
      end
      if (byte_count_ff == 8'd3) begin
         upd_id = rx_byte;
      end
      // The byte leaving the two-byte window joins the sum once it is a body byte.
      if (byte_count_ff >= 8'd4) begin
         upd_lag_sum = lag_sum_ff + {8'd0, older_ff};
      end
      length_hit = count_next >= {1'b0, cfg.expected_length};
   end

   assign ticks       = {1'b0, idle_count_ff} + 17'd1;
   assign timeout_hit = ticks > {1'b0, cfg.timeout_limit};
   assign by_timeout  = (cmd == CMD_IDLE);
   assign finish      = by_timeout ? timeout_hit : length_hit;

   // Values the end-of-frame checks look at.
   always_comb begin
      if (by_timeout) begin
         ev_count      = byte_count_ff;
         ev_lag_sum    = lag_sum_ff;
         ev_header_bad = header_bad_ff;
         ev_id         = id_byte_ff;
         ev_length     = length_byte_ff;
         ev_older      = older_ff;
         ev_newer      = newer_ff;
      end else begin
         ev_count      = upd_count;
         ev_lag_sum    = upd_lag_sum;
         ev_header_bad = upd_header_bad;
         ev_id         = upd_id;
         ev_length     = upd_length;
         ev_older      = newer_ff;
         ev_newer      = rx_byte;
      end
   end

   assign check_sum = ev_lag_sum + {ev_older, ev_newer};

   always_comb begin
      if (ev_count < 8'd3) begin
         status      = ST_TIMEOUT;
         frame_bytes = 8'd0;
      end else begin
         frame_bytes = ev_count;
         status = (by_timeout && cfg.expected_length != VARIABLE_LEN) ? ST_TIMEOUT : ST_OK;
         if (ev_count > 8'd3) begin
            if (ev_header_bad) begin
               status = ST_HEADER;
            end else if (ev_id != cfg.own_id && ev_id != cfg.broadcast_id) begin
               status = ST_ID;
            end else if (ev_length != ev_count - 8'd2) begin
               status = ST_LENGTH;
            end else if (check_sum != CHECK_GOOD) begin
               status = ST_CHECKSUM;
            end
         end
      end
   end

   // Next state: hold when not stepping, clear when the frame ends.
   always_comb begin
      byte_count_in  = byte_count_ff;
      idle_count_in  = idle_count_ff;
      lag_sum_in     = lag_sum_ff;
      header_bad_in  = header_bad_ff;
      id_byte_in     = id_byte_ff;
      length_byte_in = length_byte_ff;
      older_in       = older_ff;
      newer_in       = newer_ff;
      if (step) begin
         if (finish) begin
            byte_count_in  = 8'd0;
            idle_count_in  = 16'd0;
            lag_sum_in     = 16'd0;
            header_bad_in  = 1'b0;
            id_byte_in     = 8'd0;
            length_byte_in = 8'd0;
            older_in       = 8'd0;
            newer_in       = 8'd0;
         end else if (by_timeout) begin
            idle_count_in = ticks[15:0];
         end else begin
            byte_count_in  = upd_count;
            idle_count_in  = 16'd0;
            lag_sum_in     = upd_lag_sum;
            header_bad_in  = upd_header_bad;
            id_byte_in     = upd_id;
            length_byte_in = upd_length;
            older_in       = newer_ff;
            newer_in       = rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= 8'd0;
         idle_count_ff  <= 16'd0;
         lag_sum_ff     <= 16'd0;
         header_bad_ff  <= 1'b0;
         id_byte_ff     <= 8'd0;
         length_byte_ff <= 8'd0;
         older_ff       <= 8'd0;
         newer_ff       <= 8'd0;
      end else begin
         byte_count_ff  <= byte_count_in;
         idle_count_ff  <= idle_count_in;
         lag_sum_ff     <= lag_sum_in;
         header_bad_ff  <= header_bad_in;
         id_byte_ff     <= id_byte_in;
         length_byte_ff <= length_byte_in;
         older_ff       <= older_in;
         newer_ff       <= newer_in;
      end
   end

   assign result.done        = step & finish;
   assign result.status      = status;
   assign result.frame_bytes = frame_bytes;

endmodule

### design/servo_frame_receive_checker_core.sv
// Top level of the servo frame receive checker.
//
//   Channel    Direction  Payload                Meaning
//   req_port   in         cmd, rx_byte           one received byte or one idle tick
//   rsp_port   out        status, frame_bytes    one status per finished frame
//   csr_port   in         index, data            configuration register write
//
// One request is taken per cycle unless a stalled result holds the input register. A
// request waits in the input register, where the frame tracker updates its state and,
// if the frame ends, loads the result register; the result is offered from the result
// register once its request has passed through the input register.
// Reset is synchronous and active high; it clears the frame state and restores the
// register defaults. A stalled result holds the result register, and the input
// register then drains into it only once it has been taken, so a request waits at
// most while the result side is stalled. Register writes are always accepted.
module servo_frame_receive_checker_core
   import sfrc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   sfrc_req_if.sink    req_port,
   sfrc_rsp_if.source  rsp_port,
   sfrc_csr_if.sink    csr_port
);

   cfg_type    cfg;
   result_type result;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic       in_cmd_ff;
   logic [7:0] in_byte_ff;

   // Result register.
   logic       out_valid_ff, out_valid_in;
   logic [2:0] out_status_ff;
   logic [7:0] out_bytes_ff;

   logic advance;
   logic req_take;

   // The held request moves on whenever the result register is free or emptying,
   // whether or not it closes a frame.
   assign advance  = in_valid_ff & (~out_valid_ff | rsp_port.ready);
   assign req_take = req_port.valid & req_port.ready;

   assign req_port.ready = ~in_valid_ff | advance;
   assign csr_port.ready = 1'b1;

   sfrc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_port.valid),
      .wr_index (csr_port.index),
      .wr_data  (csr_port.data),
      .cfg      (cfg)
   );

   sfrc_frame u_frame (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .cmd     (in_cmd_ff),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff & ~rsp_port.ready;
      if (advance) begin
         out_valid_in = result.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff  <= req_port.cmd;
         in_byte_ff <= req_port.rx_byte;
      end
      if (advance && result.done) begin
         out_status_ff <= result.status;
         out_bytes_ff  <= result.frame_bytes;
      end
   end

   assign rsp_port.valid       = out_valid_ff;
   assign rsp_port.status      = out_status_ff;
   assign rsp_port.frame_bytes = out_bytes_ff;

endmodule

### design/sfrc_checker.sv
// Port-level assertions for the servo frame receive checker, bound to the top level.
module sfrc_checker
   import sfrc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [7:0] rsp_frame_bytes,
   input logic       csr_ready
);

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_frame_bytes))
      else $error("result changed while stalled");

   // Only the six defined status codes are ever reported.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_TIMEOUT
         || rsp_status == ST_HEADER || rsp_status == ST_ID
         || rsp_status == ST_LENGTH || rsp_status == ST_CHECKSUM))
      else $error("undefined status code");

   // A short frame reports zero bytes and a timeout; otherwise at least three bytes.
   a_short_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_bytes == 8'd0 && rsp_status == ST_TIMEOUT)
         || rsp_frame_bytes >= 8'd3)
      else $error("inconsistent byte count and status");

   // No result is pending straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // Register writes are never held off.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("configuration port not ready");

endmodule

bind servo_frame_receive_checker_core sfrc_checker u_sfrc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .rsp_status      (rsp_port.status),
   .rsp_frame_bytes (rsp_port.frame_bytes),
   .csr_ready       (csr_port.ready)
);
